// File: hw/rtl/depth_pixel_to_world_point_unit_macros.svh
// Assertion macros of the depth pixel to world point RTL.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_UNIT_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define DPW_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("dpw: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPW_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("dpw: next-cycle check failed");

`else

`define DPW_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define DPW_ASSERT_NXT(lbl, clk, rst_n, a, c)

`endif

`endif

// File: hw/rtl/dpw_pkg.sv
// Types, constants and helper functions of the depth pixel to world point unit.
`default_nettype none

package dpw_pkg;

	// Image index width; pixel row and column fields use it
	localparam int IMAGE_INDEX_BITS = 12;
	localparam int PIX_Q4_W         = IMAGE_INDEX_BITS + 4;
	// Signed width of (index * 16 - center), center being 16 bits unsigned
	localparam int DX_W             = ((PIX_Q4_W > 16) ? PIX_Q4_W : 16) + 1;
	// Signed width of the offset times a 32-bit unsigned reciprocal
	localparam int PRODA_W          = DX_W + 32;

	localparam int POSE_WORDS = 12;
	localparam int POSE_IDX_W = 4;
	localparam logic signed [31:0] POSE_ONE = 32'sh0001_0000;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 120;

	// Command codes carried on the input tuser
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_POSE  = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_INV_FOCAL_X = 3'd2,
		REG_INV_FOCAL_Y = 3'd3,
		REG_INV_UNIT    = 3'd4,
		REG_MIN_DEPTH   = 3'd5,
		REG_MAX_DEPTH   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [31:0] inv_focal_x;
		logic [31:0] inv_focal_y;
		logic [31:0] inv_unit;
		logic [15:0] min_depth_raw;
		logic [15:0] max_depth_raw;
	} cfg_t;

	// Fields that ride along the pipeline untouched
	typedef struct packed {
		logic                  is_pose;
		logic [POSE_IDX_W-1:0] pose_index;
		logic signed [31:0]    pose_value;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
	} side_t;

	typedef struct packed {
		logic [IMAGE_INDEX_BITS-1:0] pixel_row;
		logic [IMAGE_INDEX_BITS-1:0] pixel_col;
		logic [15:0]                 depth_raw;
		side_t                       side;
	} item_t;

	// Camera-frame point handed from back-projection to the pose transform
	typedef struct packed {
		logic               valid;
		side_t              side;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} result_t;

	localparam logic signed [63:0] SAT_MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN64 = -64'sd2147483648;

	// Clamp a signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX64) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN64) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dpw_cfg_regs.sv
// Configuration register file of the depth pixel to world point unit.
`default_nettype none

module dpw_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [dpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dpw_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dpw_pkg::cfg_t                        cfg
);
	import dpw_pkg::*;

	cfg_t cfg_q;

	// Writes are always accepted
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode the register index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.inv_focal_x   <= '0;
			cfg_q.inv_focal_y   <= '0;
			cfg_q.inv_unit      <= 32'h0001_0000;
			cfg_q.min_depth_raw <= '0;
			cfg_q.max_depth_raw <= 16'hFFFF;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:    cfg_q.center_x      <= cfg_data[15:0];
				REG_CENTER_Y:    cfg_q.center_y      <= cfg_data[15:0];
				REG_INV_FOCAL_X: cfg_q.inv_focal_x   <= cfg_data[31:0];
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y   <= cfg_data[31:0];
				REG_INV_UNIT:    cfg_q.inv_unit      <= cfg_data[31:0];
				REG_MIN_DEPTH:   cfg_q.min_depth_raw <= cfg_data[15:0];
				REG_MAX_DEPTH:   cfg_q.max_depth_raw <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dpw_backproject.sv
// Depth window, metric scaling and pinhole back-projection, stages one to five.
`default_nettype none

module dpw_backproject (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire dpw_pkg::item_t in_item,
	input  wire dpw_pkg::cfg_t  cfg,
	output dpw_pkg::point_t     out_pt
);
	import dpw_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	logic [15:0]               depth_s1;
	logic signed [DX_W-1:0]    dx_s1, dy_s1;
	logic [47:0]               za_s2;
	logic signed [PRODA_W-1:0] pa_x_s2, pa_y_s2;
	logic signed [31:0]        ax_s3, ay_s3, z_s3;
	logic signed [63:0]        mx_s4, my_s4;
	logic signed [31:0]        z_s4;
	logic signed [31:0]        x_s5, y_s5, z_s5;

	logic                   in_win;
	logic signed [DX_W-1:0] dx_c, dy_c;
	logic signed [63:0]     ax_wide, ay_wide, x_wide, y_wide;

	// Window test and principal point offsets in Q.4 pixels
	always_comb begin
		in_win = (in_item.depth_raw >= cfg.min_depth_raw) &&
			(in_item.depth_raw <= cfg.max_depth_raw);
		dx_c = $signed(DX_W'({in_item.pixel_col, 4'b0000})) - $signed(DX_W'(cfg.center_x));
		dy_c = $signed(DX_W'({in_item.pixel_row, 4'b0000})) - $signed(DX_W'(cfg.center_y));
	end

	// Round the reciprocal products and the coordinate products
	always_comb begin
		ax_wide = (64'(pa_x_s2) + 64'sd524288) >>> 20;
		ay_wide = (64'(pa_y_s2) + 64'sd524288) >>> 20;
		x_wide  = (mx_s4 + 64'sd32768) >>> 16;
		y_wide  = (my_s4 + 64'sd32768) >>> 16;
	end

	// Advance valid bits; drop pixels outside the depth window at entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && (in_item.side.is_pose || in_win);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= in_item.side;
			depth_s1 <= in_item.depth_raw;
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;

			side_s2 <= side_s1;
			za_s2   <= 48'(depth_s1) * 48'(cfg.inv_unit);
			pa_x_s2 <= dx_s1 * $signed({1'b0, cfg.inv_focal_x});
			pa_y_s2 <= dy_s1 * $signed({1'b0, cfg.inv_focal_y});

			side_s3 <= side_s2;
			z_s3    <= (za_s2 > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(za_s2[31:0]);
			ax_s3   <= sat32(ax_wide);
			ay_s3   <= sat32(ay_wide);

			side_s4 <= side_s3;
			mx_s4   <= ax_s3 * z_s3;
			my_s4   <= ay_s3 * z_s3;
			z_s4    <= z_s3;

			side_s5 <= side_s4;
			x_s5    <= sat32(x_wide);
			y_s5    <= sat32(y_wide);
			z_s5    <= z_s4;
		end
	end

	assign out_pt.valid = v_s5;
	assign out_pt.side  = side_s5;
	assign out_pt.x     = x_s5;
	assign out_pt.y     = y_s5;
	assign out_pt.z     = z_s5;

endmodule

`default_nettype wire

// File: hw/rtl/dpw_transform.sv
// Pose store and camera-to-world rigid transform, stages six and seven.
`default_nettype none

`include "depth_pixel_to_world_point_unit_macros.svh"

module dpw_transform (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire dpw_pkg::point_t in_pt,
	output logic                 out_valid,
	output dpw_pkg::result_t     out_res
);
	import dpw_pkg::*;

	logic signed [31:0] pose_q [POSE_WORDS];

	logic               valid_s6, valid_s7;
	side_t              side_s6;
	logic signed [63:0] prod_s6 [3][3];
	logic signed [31:0] trans_s6 [3];
	result_t            res_s7;

	logic               wr_pose;
	logic signed [31:0] p_c [3];
	logic signed [63:0] acc_c [3];

	assign wr_pose = adv && in_pt.valid && in_pt.side.is_pose &&
		(in_pt.side.pose_index < POSE_IDX_W'(POSE_WORDS));

	assign p_c[0] = in_pt.x;
	assign p_c[1] = in_pt.y;
	assign p_c[2] = in_pt.z;

	// Load pose words in stream order; reset to identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_WORDS; i++) begin
				pose_q[i] <= (i == 0 || i == 5 || i == 10) ? POSE_ONE : 32'sd0;
			end
		end else if (wr_pose) begin
			pose_q[in_pt.side.pose_index] <= in_pt.side.pose_value;
		end
	end

	// Sum the rounded rotation products with the translation
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = 64'(trans_s6[r]);
			for (int c = 0; c < 3; c++) begin
				acc_c[r] = acc_c[r] + ((prod_s6[r][c] + 64'sd32768) >>> 16);
			end
		end
	end

	// Advance valid bits; pose requests end here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= in_pt.valid && !in_pt.side.is_pose;
			valid_s7 <= valid_s6;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= in_pt.side;
			for (int r = 0; r < 3; r++) begin
				trans_s6[r] <= pose_q[r * 4 + 3];
				for (int c = 0; c < 3; c++) begin
					prod_s6[r][c] <= pose_q[r * 4 + c] * p_c[c];
				end
			end

			res_s7.world_x <= sat32(acc_c[0]);
			res_s7.world_y <= sat32(acc_c[1]);
			res_s7.world_z <= sat32(acc_c[2]);
			res_s7.red     <= side_s6.red;
			res_s7.green   <= side_s6.green;
			res_s7.blue    <= side_s6.blue;
		end
	end

	assign out_valid = valid_s7;
	assign out_res   = res_s7;

	// A stalled pipe keeps its occupancy
	`DPW_ASSERT_NXT(a_stall_hold, clk, arst_n, !adv, $stable(valid_s6) && $stable(valid_s7))
	// A pose request never turns into a result
	`DPW_ASSERT_NXT(a_pose_no_result, clk, arst_n, adv && in_pt.valid && in_pt.side.is_pose, !valid_s6)
	// A pose word write lands in the store
	`DPW_ASSERT_NXT(a_pose_write, clk, arst_n, wr_pose, pose_q[$past(in_pt.side.pose_index)] == $past(in_pt.side.pose_value))

endmodule

`default_nettype wire

// File: hw/rtl/depth_pixel_to_world_point_unit.sv
// Top level of the depth pixel to world point unit.
//
// Input stream (s_tvalid/s_tready/s_tdata/s_tuser): one request per cycle unless the output stalls.
//   s_tuser selects pixel (0) or pose word load (1). A pixel is scaled to
//   metres, dropped if its raw depth lies outside [min_depth_raw, max_depth_raw],
//   back-projected through the pinhole intrinsics and moved by the 3x4 pose.
//   A pose request writes one pose word if its index is below 12, gives no result
//   and takes effect in stream order, so pixels ahead of it use the old pose.
// Output stream (m_tvalid/m_tready/m_tdata): world x, y, z (Q16.16,
//   saturated) and the pixel colour.
// Requests pass through seven register stages, s1 to s7 (two multiplier stages
//   for back-projection, one for the pose products). Throughput is one request
//   per cycle while the output does not stall.
// When m_tready is low with a result waiting, the whole pipe holds and
//   s_tready drops; nothing is lost or repeated.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the
//   user writes it only while the unit is idle; the block does not check. Reset
//   empties the pipe, loads the register defaults and sets the pose to identity.
`default_nettype none

module depth_pixel_to_world_point_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pixel_row[11:0], pixel_col[23:12], depth_raw[39:24], red[47:40],
	// green[55:48], blue[63:56], pose_index[67:64], pose_value[99:68], zero pad
	input  wire logic [dpw_pkg::IN_DATA_W-1:0]    s_tdata,
	// command
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// world_x[31:0], world_y[63:32], world_z[95:64], out_red[103:96],
	// out_green[111:104], out_blue[119:112]
	output logic [dpw_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [dpw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dpw_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	point_t  cam_pt;
	result_t res;
	logic    adv;
	logic    in_valid;
	logic    res_valid;

	// Unpack the input request
	always_comb begin
		in_item.pixel_row       = s_tdata[11:0];
		in_item.pixel_col       = s_tdata[23:12];
		in_item.depth_raw       = s_tdata[39:24];
		in_item.side.red        = s_tdata[47:40];
		in_item.side.green      = s_tdata[55:48];
		in_item.side.blue       = s_tdata[63:56];
		in_item.side.pose_index = s_tdata[67:64];
		in_item.side.pose_value = $signed(s_tdata[99:68]);
		in_item.side.is_pose    = (s_tuser == CMD_POSE);
	end

	// Advance the whole pipe unless a result waits on a stalled receiver
	assign adv      = !res_valid || m_tready;
	assign s_tready = adv;
	assign in_valid = s_tvalid && adv;

	dpw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpw_backproject u_bp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_item  (in_item),
		.cfg      (cfg),
		.out_pt   (cam_pt)
	);

	dpw_transform u_xf (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_pt     (cam_pt),
		.out_valid (res_valid),
		.out_res   (res)
	);

	// Pack the result
	assign m_tvalid = res_valid;
	assign m_tdata  = {res.blue, res.green, res.red, res.world_z, res.world_y, res.world_x};

endmodule

`default_nettype wire

// File: tb/sv/tb_depth_pixel_to_world_point_unit.sv
// Testbench of the depth pixel to world point unit: directed and random requests against a scoreboard.
module tb_depth_pixel_to_world_point_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dpw_pkg::*;

	// Register index past the last defined register; writes to it must do nothing
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int DRAIN_CYCLES    = 16;
	localparam int IDLE_LIMIT      = 4000;
	localparam int CHOKE_CYCLES    = 80;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 136;
	localparam int CHOKE_PHASE     = 2;

	typedef enum {CFG_PLAUSIBLE, CFG_ANY, CFG_ALL_LOW, CFG_ALL_HIGH} cfg_kind_t;

	typedef struct packed {
		logic               command;
		logic [11:0]        pixel_row;
		logic [11:0]        pixel_col;
		logic [15:0]        depth_raw;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [3:0]         pose_index;
		logic signed [31:0] pose_value;
	} stream_req_t;

	// Mirror of the unit: registers, pose words and the queue of expected world points
	class world_point_scoreboard;
		cfg_t               cfg;
		logic signed [31:0] pose[POSE_WORDS];
		result_t            expected_points[$];
		int                 errors;

		function new();
			cfg = '0;
			cfg.inv_unit = 32'd65536;
			cfg.max_depth_raw = 16'hFFFF;
			for (int i = 0; i < POSE_WORDS; i++) pose[i] = '0;
			pose[0] = POSE_ONE;
			pose[5] = POSE_ONE;
			pose[10] = POSE_ONE;
			errors = 0;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
			case (index)
				REG_CENTER_X:    cfg.center_x = value[15:0];
				REG_CENTER_Y:    cfg.center_y = value[15:0];
				REG_INV_FOCAL_X: cfg.inv_focal_x = value;
				REG_INV_FOCAL_Y: cfg.inv_focal_y = value;
				REG_INV_UNIT:    cfg.inv_unit = value;
				REG_MIN_DEPTH:   cfg.min_depth_raw = value[15:0];
				REG_MAX_DEPTH:   cfg.max_depth_raw = value[15:0];
				default: ;
			endcase
		endfunction

		function longint clamp_s32(longint v);
			if (v > S32_MAX) return S32_MAX;
			if (v < S32_MIN) return S32_MIN;
			return v;
		endfunction

		// Halves round toward plus infinity
		function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		// Pixel index to camera-frame coordinate at depth z
		function longint back_project(logic [11:0] idx, logic [15:0] center,
				logic [31:0] inv_f, longint z);
			longint offset;
			longint angle;
			offset = longint'(idx) * 16 - longint'(center);
			angle = clamp_s32(round_shift(offset * longint'(inv_f), 20));
			return clamp_s32(round_shift(angle * z, 16));
		endfunction

		// Update the pose or predict the world point of one accepted request
		function void note_request(logic [IN_DATA_W-1:0] data, logic command);
			logic [3:0]  index;
			logic [15:0] depth;
			longint      cam[3];
			longint      world[3];
			longint      acc;
			longint      zu;
			result_t     point;
			if (command == CMD_POSE) begin
				index = data[67:64];
				if (index < POSE_WORDS) pose[index] = data[99:68];
				return;
			end
			depth = data[39:24];
			if (depth < cfg.min_depth_raw || depth > cfg.max_depth_raw) return;
			zu = longint'(depth) * longint'(cfg.inv_unit);
			cam[2] = (zu > S32_MAX) ? S32_MAX : zu;
			cam[0] = back_project(data[23:12], cfg.center_x, cfg.inv_focal_x, cam[2]);
			cam[1] = back_project(data[11:0], cfg.center_y, cfg.inv_focal_y, cam[2]);
			for (int r = 0; r < 3; r++) begin
				acc = longint'(pose[r * 4 + 3]);
				for (int c = 0; c < 3; c++)
					acc += round_shift(longint'(pose[r * 4 + c]) * cam[c], 16);
				world[r] = clamp_s32(acc);
			end
			point.world_x = world[0][31:0];
			point.world_y = world[1][31:0];
			point.world_z = world[2][31:0];
			point.red = data[47:40];
			point.green = data[55:48];
			point.blue = data[63:56];
			expected_points.insert(expected_points.size(), point);
		endfunction

		function void compare_field(string field_name, longint want, longint got);
			if (want != got) begin
				errors++;
				$error("%s mismatch: expected %0d, got %0d", field_name, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest expected point
		function void check_result(logic [OUT_DATA_W-1:0] data);
			result_t want;
			if (expected_points.size() == 0) begin
				errors++;
				$error("result with no point expected: %h", data);
				return;
			end
			want = expected_points.pop_front();
			compare_field("world_x", want.world_x, $signed(data[31:0]));
			compare_field("world_y", want.world_y, $signed(data[63:32]));
			compare_field("world_z", want.world_z, $signed(data[95:64]));
			compare_field("out_red", want.red, data[103:96]);
			compare_field("out_green", want.green, data[111:104]);
			compare_field("out_blue", want.blue, data[119:112]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// pixel_row, pixel_col, depth_raw, red, green, blue, pose_index, pose_value, zero pad
	logic [IN_DATA_W-1:0]   s_tdata;
	// command
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// world_x, world_y, world_z, out_red, out_green, out_blue
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	world_point_scoreboard sb;
	cfg_t                  cur_cfg;
	int                    burst_left;
	bit                    choke_req;

	depth_pixel_to_world_point_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watch every handshake and feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	// Receiver: stall in segments of varying density, plus long hold-offs on demand
	initial begin
		int seg_left;
		int mode;
		int stall_left;
		seg_left = 0;
		mode = 0;
		stall_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (choke_req) begin
				choke_req = 1'b0;
				stall_left = CHOKE_CYCLES;
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(10, 150);
			end
			seg_left--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (seg_left % 4 != 0);
				endcase
			end
		end
	end

	// Offer one request and hold it until accepted; open a gap at the end of a burst
	task automatic send_request(input stream_req_t req, input bit allow_gap);
		int gap;
		s_tuser <= req.command;
		s_tdata <= {4'b0, req.pose_value, req.pose_index, req.blue, req.green, req.red,
			req.depth_raw, req.pixel_col, req.pixel_row};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (!allow_gap) return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every expected point plus the pipeline latency
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < IDLE_LIMIT && sb.pending() != 0; n++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
		cfg_index <= index;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register, then poke the unused index
	task automatic load_config(input cfg_t c);
		write_reg(REG_CENTER_X, {16'b0, c.center_x});
		write_reg(REG_CENTER_Y, {16'b0, c.center_y});
		write_reg(REG_INV_FOCAL_X, c.inv_focal_x);
		write_reg(REG_INV_FOCAL_Y, c.inv_focal_y);
		write_reg(REG_INV_UNIT, c.inv_unit);
		write_reg(REG_MIN_DEPTH, {16'b0, c.min_depth_raw});
		write_reg(REG_MAX_DEPTH, {16'b0, c.max_depth_raw});
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		cur_cfg = c;
		@(posedge clk);
	endtask

	// Pixel request; the unused pose fields carry noise
	function automatic stream_req_t make_pixel(int row, int col, int depth,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		stream_req_t req;
		req.command = CMD_PIXEL;
		req.pixel_row = row;
		req.pixel_col = col;
		req.depth_raw = depth;
		req.red = r;
		req.green = g;
		req.blue = b;
		req.pose_index = $urandom;
		req.pose_value = $urandom;
		return req;
	endfunction

	// Pose word request; the unused pixel fields carry noise
	function automatic stream_req_t make_pose(int index, logic signed [31:0] value);
		stream_req_t req;
		req = make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		req.command = CMD_POSE;
		req.pose_index = index;
		req.pose_value = value;
		return req;
	endfunction

	function automatic stream_req_t random_request();
		stream_req_t req;
		int          pick;
		req = make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom,
			$urandom, $urandom, $urandom);
		// Keep most depths inside the window so results stay frequent
		if ($urandom_range(0, 4) != 0)
			req.depth_raw = $urandom_range(cur_cfg.max_depth_raw, cur_cfg.min_depth_raw);
		if ($urandom_range(0, 19) < 3) begin
			req.command = CMD_POSE;
			req.pose_index = ($urandom_range(0, 9) == 0) ? $urandom_range(POSE_WORDS, 15)
				: $urandom_range(0, POSE_WORDS - 1);
			pick = $urandom_range(0, 7);
			if (pick == 0)
				req.pose_value = $urandom;
			else if (pick < 3)
				req.pose_value = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
			else
				req.pose_value = int'($urandom_range(0, 2 * 65536)) - 65536;
		end
		return req;
	endfunction

	function automatic cfg_t random_config(cfg_kind_t kind);
		cfg_t        c;
		logic [15:0] swap;
		c = '0;
		case (kind)
			CFG_PLAUSIBLE: begin
				c.center_x = $urandom_range(0, 4095 * 16);
				c.center_y = $urandom_range(0, 4095 * 16);
				c.inv_focal_x = 32'hFFFF_FFFF / $urandom_range(50, 4000);
				c.inv_focal_y = 32'hFFFF_FFFF / $urandom_range(50, 4000);
				c.inv_unit = $urandom_range(1, 70000);
				c.min_depth_raw = $urandom_range(0, 3000);
				c.max_depth_raw = c.min_depth_raw + $urandom_range(0, 30000);
			end
			CFG_ANY: begin
				c.center_x = $urandom;
				c.center_y = $urandom;
				c.inv_focal_x = $urandom;
				c.inv_focal_y = $urandom;
				c.inv_unit = $urandom;
				c.min_depth_raw = $urandom;
				c.max_depth_raw = $urandom;
				// Mostly keep the window open
				if (c.min_depth_raw > c.max_depth_raw && $urandom_range(0, 3) != 0) begin
					swap = c.min_depth_raw;
					c.min_depth_raw = c.max_depth_raw;
					c.max_depth_raw = swap;
				end
			end
			CFG_ALL_HIGH: begin
				c.center_x = 16'hFFFF;
				c.center_y = 16'hFFFF;
				c.inv_focal_x = 32'hFFFF_FFFF;
				c.inv_focal_y = 32'hFFFF_FFFF;
				c.inv_unit = 32'hFFFF_FFFF;
				c.min_depth_raw = 16'hFFFF;
				c.max_depth_raw = 16'hFFFF;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Stimulus
	initial begin
		cfg_t      c;
		cfg_kind_t kind;
		bit        steady;
		sb = new();
		cur_cfg = '0;
		cur_cfg.inv_unit = 32'd65536;
		cur_cfg.max_depth_raw = 16'hFFFF;
		burst_left = 0;
		choke_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_PIXEL;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: zero reciprocals put every point on the optical axis
		send_request(make_pixel(0, 0, 0, 8'h00, 8'h00, 8'h00), 1'b1);
		send_request(make_pixel(4095, 4095, 65535, 8'hFF, 8'hFF, 8'hFF), 1'b1);
		send_request(make_pixel(2048, 1024, 32767, 8'hA5, 8'h5A, 8'h3C), 1'b1);
		// Pose indexes past the last word are ignored
		send_request(make_pose(15, $urandom), 1'b1);
		send_request(make_pose(POSE_WORDS, $urandom), 1'b1);
		send_request(make_pixel(100, 200, 1, 8'h01, 8'h02, 8'h03), 1'b1);
		wait_idle();

		// Typical camera, millimetre depth, window edges
		c.center_x = 16'd5120;
		c.center_y = 16'd3840;
		c.inv_focal_x = 32'd8181011;
		c.inv_focal_y = 32'd8181011;
		c.inv_unit = 32'd66;
		c.min_depth_raw = 16'd100;
		c.max_depth_raw = 16'd5000;
		load_config(c);
		send_request(make_pixel(240, 320, 99, 8'h10, 8'h20, 8'h30), 1'b1);
		send_request(make_pixel(240, 320, 100, 8'h11, 8'h21, 8'h31), 1'b1);
		send_request(make_pixel(240, 320, 5000, 8'h12, 8'h22, 8'h32), 1'b1);
		send_request(make_pixel(240, 320, 5001, 8'h13, 8'h23, 8'h33), 1'b1);
		send_request(make_pixel(0, 0, 1000, 8'h14, 8'h24, 8'h34), 1'b1);
		send_request(make_pixel(4095, 4095, 1000, 8'h15, 8'h25, 8'h35), 1'b1);
		// Extreme pose words drive the sums into saturation
		send_request(make_pose(3, 32'sh7FFF_FFFF), 1'b1);
		send_request(make_pose(0, 32'sh8000_0000), 1'b1);
		send_request(make_pixel(0, 0, 5000, 8'h16, 8'h26, 8'h36), 1'b1);
		send_request(make_pose(7, 32'sh8000_0000), 1'b1);
		send_request(make_pixel(4095, 0, 4000, 8'h17, 8'h27, 8'h37), 1'b1);
		send_request(make_pose(0, POSE_ONE), 1'b1);
		send_request(make_pose(3, 32'sh0), 1'b1);
		send_request(make_pose(7, 32'sh0), 1'b1);
		wait_idle();

		// Empty window: every pixel is dropped
		c.min_depth_raw = 16'd6000;
		load_config(c);
		send_request(make_pixel(10, 10, 5500, 8'h40, 8'h41, 8'h42), 1'b1);
		send_request(make_pixel(10, 10, 5000, 8'h43, 8'h44, 8'h45), 1'b1);
		wait_idle();

		// All registers at their top values but the minimum depth, which is zero
		load_config(random_config(CFG_ALL_HIGH));
		c = cur_cfg;
		c.min_depth_raw = 16'd0;
		load_config(c);
		send_request(make_pixel(0, 0, 65535, 8'h80, 8'h81, 8'h82), 1'b1);
		send_request(make_pixel(4095, 4095, 1, 8'h83, 8'h84, 8'h85), 1'b1);
		send_request(make_pixel(4095, 0, 0, 8'h86, 8'h87, 8'h88), 1'b1);
		wait_idle();

		// Random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 3)
				kind = CFG_ALL_LOW;
			else if (p == 5)
				kind = CFG_ALL_HIGH;
			else if (p % 3 == 1)
				kind = CFG_ANY;
			else
				kind = CFG_PLAUSIBLE;
			load_config(random_config(kind));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Hold off the output while requests keep coming back to back
				steady = (p == CHOKE_PHASE && i >= 30 && i < 90);
				if (p == CHOKE_PHASE && i == 30) choke_req = 1'b1;
				send_request(random_request(), !steady);
			end
			wait_idle();
		end

		if (sb.pending() != 0) begin
			sb.errors++;
			$error("%0d expected points never arrived", sb.pending());
		end
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: depth_pixel_to_world_point_unit.f
+incdir+hw/rtl
hw/rtl/dpw_pkg.sv
hw/rtl/dpw_cfg_regs.sv
hw/rtl/dpw_backproject.sv
hw/rtl/dpw_transform.sv
hw/rtl/depth_pixel_to_world_point_unit.sv
tb/sv/tb_depth_pixel_to_world_point_unit.sv
